@@ src/vmr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vmr_pkg
// Shared types and constants for the register/ALU core: instruction group
// codes, ALU sub-op codes, field widths and the execute result bundle.
// ----------------------------------------------------------------------------
package vmr_pkg;

	localparam int unsigned AddrW = 12;
	localparam int unsigned ByteW = 8;
	localparam int unsigned NibW  = 4;
	localparam int unsigned InsW  = 16;

	localparam logic [AddrW-1:0] PC_RESET = 12'd512;
	localparam logic [AddrW-1:0] PC_STEP  = 12'd2;
	localparam logic [NibW-1:0]  FLAG_REG = 4'hF;
	localparam logic [NibW-1:0]  BASE_REG = 4'h0;

	// instruction groups (top nibble)
	localparam logic [NibW-1:0] GRP_JP    = 4'h1;
	localparam logic [NibW-1:0] GRP_SE_NN = 4'h3;
	localparam logic [NibW-1:0] GRP_SN_NN = 4'h4;
	localparam logic [NibW-1:0] GRP_SE_XY = 4'h5;
	localparam logic [NibW-1:0] GRP_LD_NN = 4'h6;
	localparam logic [NibW-1:0] GRP_ADD_NN = 4'h7;
	localparam logic [NibW-1:0] GRP_ALU   = 4'h8;
	localparam logic [NibW-1:0] GRP_SN_XY = 4'h9;
	localparam logic [NibW-1:0] GRP_LD_I  = 4'hA;
	localparam logic [NibW-1:0] GRP_JP_V0 = 4'hB;
	localparam logic [NibW-1:0] GRP_RND   = 4'hC;

	// ALU group sub-ops (low nibble)
	localparam logic [NibW-1:0] ALU_MOV = 4'h0;
	localparam logic [NibW-1:0] ALU_OR  = 4'h1;
	localparam logic [NibW-1:0] ALU_AND = 4'h2;
	localparam logic [NibW-1:0] ALU_XOR = 4'h3;
	localparam logic [NibW-1:0] ALU_ADD = 4'h4;
	localparam logic [NibW-1:0] ALU_SUB = 4'h5;
	localparam logic [NibW-1:0] ALU_SHR = 4'h6;
	localparam logic [NibW-1:0] ALU_SBN = 4'h7;
	localparam logic [NibW-1:0] ALU_SHL = 4'hE;

	// execute result handed from the execute unit to the state update
	typedef struct packed {
		logic             wr_x;      // Vx gets x_val
		logic [ByteW-1:0] x_val;
		logic             has_flag;  // VF gets flag_bit after Vx
		logic             flag_bit;
		logic             wr_index;  // index register gets nnn
		logic [AddrW-1:0] next_pc;
		logic             bad;       // not executed here
	} exec_res_t;

endpackage
`default_nettype wire

@@ src/vmr_exec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vmr_exec
// Execute unit: decodes one instruction against the operand values and
// current PC and returns what is to be written back.
// ----------------------------------------------------------------------------
module vmr_exec (
	input  wire logic [vmr_pkg::InsW-1:0]  instruction,
	input  wire logic [vmr_pkg::ByteW-1:0] random_byte,
	input  wire logic [vmr_pkg::ByteW-1:0] vx,
	input  wire logic [vmr_pkg::ByteW-1:0] vy,
	input  wire logic [vmr_pkg::AddrW-1:0] pc,
	output vmr_pkg::exec_res_t             res
);
	import vmr_pkg::*;

	logic [NibW-1:0]  grp;
	logic [NibW-1:0]  n;
	logic [ByteW-1:0] nn;
	logic [AddrW-1:0] nnn;
	logic [AddrW-1:0] pc_inc;
	logic [ByteW:0]   sum;
	logic             skip;

	assign grp    = instruction[15:12];
	assign n      = instruction[3:0];
	assign nn     = instruction[7:0];
	assign nnn    = instruction[11:0];
	assign pc_inc = pc + PC_STEP;
	assign sum    = {1'b0, vx} + {1'b0, vy};

	// decode and compute
	always_comb begin
		res          = '0;
		skip         = 1'b0;
		res.next_pc  = pc_inc;
		case (grp)
			GRP_JP: begin
				res.next_pc = nnn;
			end
			GRP_SE_NN: skip = (vx == nn);
			GRP_SN_NN: skip = (vx != nn);
			GRP_SE_XY: begin
				if (n != 4'h0) res.bad = 1'b1;
				else skip = (vx == vy);
			end
			GRP_SN_XY: begin
				if (n != 4'h0) res.bad = 1'b1;
				else skip = (vx != vy);
			end
			GRP_LD_NN: begin
				res.wr_x  = 1'b1;
				res.x_val = nn;
			end
			GRP_ADD_NN: begin
				res.wr_x  = 1'b1;
				res.x_val = vx + nn;
			end
			GRP_ALU: begin
				res.wr_x = 1'b1;
				case (n)
					ALU_MOV: res.x_val = vy;
					ALU_OR:  res.x_val = vx | vy;
					ALU_AND: res.x_val = vx & vy;
					ALU_XOR: res.x_val = vx ^ vy;
					ALU_ADD: begin
						res.x_val    = sum[ByteW-1:0];
						res.has_flag = 1'b1;
						res.flag_bit = sum[ByteW];
					end
					ALU_SUB: begin
						res.x_val    = vx - vy;
						res.has_flag = 1'b1;
						res.flag_bit = (vx >= vy);
					end
					ALU_SHR: begin
						res.x_val    = {1'b0, vx[ByteW-1:1]};
						res.has_flag = 1'b1;
						res.flag_bit = vx[0];
					end
					ALU_SBN: begin
						res.x_val    = vy - vx;
						res.has_flag = 1'b1;
						res.flag_bit = (vy >= vx);
					end
					ALU_SHL: begin
						res.x_val    = {vx[ByteW-2:0], 1'b0};
						res.has_flag = 1'b1;
						res.flag_bit = vx[ByteW-1];
					end
					default: begin
						res.wr_x = 1'b0;
						res.bad  = 1'b1;
					end
				endcase
			end
			GRP_LD_I: res.wr_index = 1'b1;
			// vy carries V0 for this group
			GRP_JP_V0: res.next_pc = nnn + {{(AddrW-ByteW){1'b0}}, vy};
			GRP_RND: begin
				res.wr_x  = 1'b1;
				res.x_val = random_byte & nn;
			end
			default: res.bad = 1'b1;
		endcase
		if (skip) res.next_pc = pc_inc + PC_STEP;
	end

endmodule
`default_nettype wire

@@ src/vm_register_alu_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vm_register_alu_core
// Register/ALU core: executes one 16-bit instruction per request against
// sixteen 8-bit registers (V0..VE in a register memory, VF in a flop),
// a 12-bit PC and a 12-bit index register.
// ----------------------------------------------------------------------------
//  channel   dir  signals                      contents
//  s_*       in   tvalid tready tdata[23:0]    instruction, random_byte
//  m_*       out  tvalid tready tdata[39:0]    next_pc, index_value,
//                 tuser[0]                     target_value, flag_value;
//                                              unsupported
//  cfg_*     in   we wdata[11:0]               program_start (also loads PC)
//
//  The accept edge reads Vx and Vy from the register memory into the execute
//  stage; once the output register is free, that stage executes, writes back
//  and loads the output register. A new request is taken every cycle unless
//  the output stalls; a same-register read right after a write uses a bypass.
//  Reset clears the registers (valid bits per memory entry), sets PC to 512.
//  The block stalls only when the output register is full and not taken.
// ----------------------------------------------------------------------------
module vm_register_alu_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [15:0] instruction, [23:16] random_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [11:0] next_pc, [23:12] index_value,
	                                    // [31:24] target_value, [39:32] flag_value
	output logic [0:0]       m_tuser,   // [0] unsupported
	input  wire logic        cfg_we,
	input  wire logic [vmr_pkg::AddrW-1:0] cfg_wdata
);
	import vmr_pkg::*;

	localparam int unsigned NumRegs = 1 << NibW;

	// register memory and its entry valid bits
	logic [ByteW-1:0]   mem [NumRegs];
	logic [NumRegs-1:0] ent_valid_q;

	logic [AddrW-1:0] pc_q;
	logic [AddrW-1:0] idx_q;
	logic [ByteW-1:0] vf_q;

	logic             valid_s1;
	logic [InsW-1:0]  ins_s1;
	logic [ByteW-1:0] rnd_s1;
	logic [ByteW-1:0] rdx_s1;
	logic [ByteW-1:0] rdy_s1;

	logic             out_valid_q;
	logic [39:0]      out_data_q;
	logic             out_bad_q;

	logic             accept;
	logic             advance;
	logic [NibW-1:0]  in_x;
	logic [NibW-1:0]  in_rb;
	logic [NibW-1:0]  x_s1;
	logic [NibW-1:0]  y_s1;
	logic [ByteW-1:0] vx;
	logic [ByteW-1:0] vy;
	logic             mem_we;
	logic [ByteW-1:0] new_vx;
	logic [ByteW-1:0] new_vf;
	logic [ByteW-1:0] target;
	logic [AddrW-1:0] new_idx;
	exec_res_t        res;

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// read addresses: x, and y or V0 for the base-jump group
	assign in_x  = s_tdata[11:8];
	assign in_rb = (s_tdata[15:12] == GRP_JP_V0) ? BASE_REG : s_tdata[7:4];

	// register memory: one write, two registered reads with write bypass
	always_ff @(posedge clk) begin
		if (mem_we) mem[x_s1] <= new_vx;
		if (accept) begin
			ins_s1 <= s_tdata[15:0];
			rnd_s1 <= s_tdata[23:16];
			if (mem_we && x_s1 == in_x) rdx_s1 <= new_vx;
			else rdx_s1 <= ent_valid_q[in_x] ? mem[in_x] : '0;
			if (mem_we && x_s1 == in_rb) rdy_s1 <= new_vx;
			else rdy_s1 <= ent_valid_q[in_rb] ? mem[in_rb] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
		end else if (mem_we) begin
			ent_valid_q[x_s1] <= 1'b1;
		end
	end

	// execute stage operands; VF lives in its own flop
	assign x_s1 = ins_s1[11:8];
	assign y_s1 = ins_s1[7:4];
	assign vx   = (x_s1 == FLAG_REG) ? vf_q : rdx_s1;
	assign vy   = (y_s1 == FLAG_REG && ins_s1[15:12] != GRP_JP_V0) ? vf_q : rdy_s1;

	vmr_exec u_exec (
		.instruction (ins_s1),
		.random_byte (rnd_s1),
		.vx          (vx),
		.vy          (vy),
		.pc          (pc_q),
		.res         (res)
	);

	// write-back values; flag lands after the result
	assign new_vx  = res.wr_x ? res.x_val : vx;
	assign new_vf  = res.has_flag ? {{(ByteW-1){1'b0}}, res.flag_bit} :
	                 (res.wr_x && x_s1 == FLAG_REG) ? res.x_val : vf_q;
	assign target  = (x_s1 == FLAG_REG) ? new_vf : new_vx;
	assign new_idx = res.wr_index ? ins_s1[11:0] : idx_q;
	assign mem_we  = advance && res.wr_x && x_s1 != FLAG_REG;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= PC_RESET;
			idx_q       <= '0;
			vf_q        <= '0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (cfg_we) pc_q <= cfg_wdata;
			else if (advance) pc_q <= res.next_pc;
			if (advance) begin
				idx_q <= new_idx;
				vf_q  <= new_vf;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {new_vf, target, new_idx, res.next_pc};
			out_bad_q  <= res.bad;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_bad_q;

	// checks
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("input taken while execute stage is stalled");
	a_no_vf_mem: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> x_s1 != FLAG_REG)
		else $error("register memory written at the flag entry");
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost before execute");
	a_bad_keeps_idx: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.bad |=> idx_q == $past(idx_q) && vf_q == $past(vf_q))
		else $error("unsupported instruction changed state");
	a_out_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(advance))
		else $error("result shown without an executed instruction");

endmodule
`default_nettype wire
